### hdl/rlsa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLSA line threshold package
// Widths, limits, register indexes and sequencer states shared by the core.
// ---------------------------------------------------------------------------
package rlsa_pkg;

   // longest line the run statistics are sized for
   localparam int LINE_MAX        = 4096;
   localparam int RUN_MAX         = LINE_MAX - 1;
   localparam int RUN_W           = $clog2(LINE_MAX);
   localparam int GAP_W           = $clog2(LINE_MAX + 1);
   localparam int SUM_W           = 2 * RUN_W;

   localparam int PIX_W           = 8;
   localparam int PIX_WHITE_LEVEL = 150;

   localparam int K_W             = 16;
   localparam int LIMIT_W         = 20;
   localparam int BIT_W           = $clog2(LIMIT_W);

   // shared multiplier operand width
   localparam int MUL_W           = 32;
   // trial value squared
   localparam int SQ_W            = 2 * LIMIT_W;
   // k*k*sum with the 16-bit fraction of the Q8.8 k squared dropped
   localparam int R_W             = 2 * K_W + SUM_W - 16;
   // trial squared times gap count
   localparam int ACC_W           = SQ_W + GAP_W;

   localparam int CSR_IDX_W       = 8;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_K     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_WHITE = 8'd1;

   localparam logic [K_W-1:0] SCALE_K_RESET     = 16'd256;
   localparam logic           COUNT_WHITE_RESET = 1'b1;

   typedef enum logic [2:0] {
      ST_PIXEL,
      ST_KK,
      ST_KS,
      ST_SQ,
      ST_MLO,
      ST_MHI,
      ST_CMP,
      ST_OUT
   } state_type;

endpackage

### hdl/rlsa_line_run_threshold_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLSA line run-length threshold core
// Gathers squared run lengths over one scan line and, at the line end,
// returns floor(k * sqrt(sum / count)) by a bit-by-bit square-root search.
// ---------------------------------------------------------------------------
// Sequence: a non-final pixel updates the run statistics. A line end runs 2
//    set-up multiplies, then square, low and high multiply and compare per
//    result bit (20 bits), then output; a gapless line goes straight there.
// Throughput: one pixel per cycle inside a line; a line end holds off requests
//    until its result is registered; all steps share one 32x32 multiplier.
// Reset: synchronous, active high; scale_k returns to 1.0, count_white to 1,
//    run statistics clear and no result is pending.
// ---------------------------------------------------------------------------
module rlsa_line_run_threshold_core
   import rlsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // pixel requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] pixel
   input  logic                  req_tlast,   // line_end

   // line results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [19:0] limit, [23:20] zero

   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(RUN_MAX * RUN_MAX);

   // configuration
   logic [K_W-1:0]     scale_k_ff;
   logic               count_white_ff;

   // line statistics
   logic [RUN_W-1:0]   run_ff,   run_in;
   logic [GAP_W-1:0]   gap_ff,   gap_in;
   logic [SUM_W-1:0]   sum_ff,   sum_in;

   // root search working registers
   state_type          state_ff, state_in;
   logic [R_W-1:0]     r_ff,     r_in;
   logic [SQ_W-1:0]    sq_ff,    sq_in;
   logic [ACC_W-1:0]   acc_ff,   acc_in;
   logic [LIMIT_W-1:0] y_ff,     y_in;
   logic [BIT_W-1:0]   bit_ff,   bit_in;

   // result register
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // shared multiplier
   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [2*MUL_W-1:0] prod;

   logic               req_accept;
   logic               pixel_white;
   logic               pixel_match;
   logic [RUN_W-1:0]   run_nxt;
   logic [GAP_W-1:0]   gap_nxt;
   logic [SUM_W-1:0]   sum_nxt;
   logic [SUM_W:0]     sum_add;
   logic [LIMIT_W-1:0] trial;
   logic               out_free;

   assign prod        = mul_a * mul_b;

   assign req_tready  = (state_ff == ST_PIXEL);
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {{(24 - LIMIT_W){1'b0}}, limit_ff};
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // candidate with the current result bit set
   assign trial       = y_ff | (LIMIT_W'(1) << bit_ff);

   // binarise and classify the pixel against the selected colour
   assign pixel_white = req_tdata[PIX_W-1:0] > PIX_W'(PIX_WHITE_LEVEL);
   assign pixel_match = (pixel_white == count_white_ff);

   // line statistics after this pixel; the multiplier squares the run here
   assign sum_add     = {1'b0, sum_ff} + {1'b0, prod[SUM_W-1:0]};

   always_comb begin
      run_nxt = run_ff;
      gap_nxt = gap_ff;
      sum_nxt = sum_ff;
      if (pixel_match) begin
         if (run_ff < RUN_W'(RUN_MAX)) begin
            run_nxt = run_ff + 1'b1;
         end
      end else begin
         run_nxt = '0;
         if (gap_ff < GAP_W'(LINE_MAX)) begin
            gap_nxt = gap_ff + 1'b1;
         end
         // saturate the sum of squares at the full-line bound
         if (sum_add > {1'b0, SUM_CAP}) begin
            sum_nxt = SUM_CAP;
         end else begin
            sum_nxt = sum_add[SUM_W-1:0];
         end
      end
   end

   // configuration writes: indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_k_ff     <= SCALE_K_RESET;
         count_white_ff <= COUNT_WHITE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SCALE_K) begin
            scale_k_ff <= csr_data[K_W-1:0];
         end else if (csr_index == CSR_COUNT_WHITE) begin
            count_white_ff <= csr_data[0];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PIXEL;
         run_ff       <= '0;
         gap_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         gap_ff       <= gap_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      y_ff     <= y_in;
      bit_ff   <= bit_in;
      limit_ff <= limit_in;
   end

   // sequencer: the search tests y*y*count <= (k*k*sum) >> 16 per result bit
   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      gap_in       = gap_ff;
      sum_in       = sum_ff;
      r_in         = r_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      y_in         = y_ff;
      bit_in       = bit_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         ST_PIXEL: begin
            mul_a = MUL_W'(run_ff);
            mul_b = MUL_W'(run_ff);
            if (req_accept) begin
               gap_in = gap_nxt;
               sum_in = sum_nxt;
               if (req_tlast) begin
                  // drop the open run and start the search, or output at once with no gap
                  run_in = '0;
                  y_in   = '0;
                  bit_in = BIT_W'(LIMIT_W - 1);
                  if (gap_nxt == '0) begin
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_KK;
                  end
               end else begin
                  run_in = run_nxt;
               end
            end
         end
         ST_KK: begin
            mul_a    = MUL_W'(scale_k_ff);
            mul_b    = MUL_W'(scale_k_ff);
            r_in     = R_W'(prod[2*K_W-1:0]);
            state_in = ST_KS;
         end
         ST_KS: begin
            mul_a    = MUL_W'(r_ff[2*K_W-1:0]);
            mul_b    = MUL_W'(sum_ff);
            r_in     = prod[R_W+15:16];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a    = MUL_W'(trial);
            mul_b    = MUL_W'(trial);
            sq_in    = prod[SQ_W-1:0];
            state_in = ST_MLO;
         end
         ST_MLO: begin
            mul_a    = sq_ff[MUL_W-1:0];
            mul_b    = MUL_W'(gap_ff);
            acc_in   = prod[ACC_W-1:0];
            state_in = ST_MHI;
         end
         ST_MHI: begin
            mul_a    = MUL_W'(sq_ff[SQ_W-1:MUL_W]);
            mul_b    = MUL_W'(gap_ff);
            acc_in   = acc_ff + (ACC_W'(prod[MUL_W-1:0]) << MUL_W);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (acc_ff <= ACC_W'(r_ff)) begin
               y_in = trial;
            end
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_OUT: begin
            // hold until the result register is free, then clear the line
            if (out_free) begin
               limit_in     = y_ff;
               rsp_valid_in = 1'b1;
               gap_in       = '0;
               sum_in       = '0;
               state_in     = ST_PIXEL;
            end
         end
         default: begin
            state_in = ST_PIXEL;
         end
      endcase
   end

   // the result bit under test stays within the result width
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (bit_ff < BIT_W'(LIMIT_W)))
      else $error("result bit index out of range");

   // a passing compare sets the bit that was under test
   a_bit_taken: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && acc_ff <= ACC_W'(r_ff)) |=>
      ((y_ff & (LIMIT_W'(1) << $past(bit_ff))) != '0))
      else $error("passing compare did not set the result bit");

   // a line end with gaps starts the multiply sequence
   a_line_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast && gap_nxt != '0) |=> (state_ff == ST_KK))
      else $error("line end did not start the search");

   // a new result never overwrites one still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(limit_ff)))
      else $error("pending result lost");

   // the statistics stay within their line bounds
   a_stat_bound: assert property (@(posedge clock) disable iff (reset)
      (gap_ff <= GAP_W'(LINE_MAX)) && (sum_ff <= SUM_CAP))
      else $error("line statistics out of bounds");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line run-length threshold core testbench
// Streams scan lines of gray pixels into the core and checks every line limit
// against a cycle-free predictor of the run statistics and the exact
// k * sqrt(sum / count) search. Short hand-picked lines and a few longer
// lines come first, then random lines under several register settings, with
// bursty requests and a patterned result stall.
// ---------------------------------------------------------------------------
module tb_top
   import rlsa_pkg::*;
();

   localparam int          RSP_W   = 24;
   localparam int unsigned SUM_CAP = RUN_MAX * RUN_MAX;

   // Predicts the limit of each line and holds the limits not yet returned.
   class limit_checker;
      logic [K_W-1:0]     scale_k;
      logic               count_white;
      logic [RUN_W-1:0]   run_len;
      logic [GAP_W-1:0]   gaps;
      logic [SUM_W-1:0]   sq_sum;
      logic [LIMIT_W-1:0] limits_due[$];
      int                 mismatches;
      int                 checked;

      function new();
         scale_k     = SCALE_K_RESET;
         count_white = COUNT_WHITE_RESET;
         run_len     = '0;
         gaps        = '0;
         sq_sum      = '0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_SCALE_K) begin
            scale_k = data[K_W-1:0];
         end else if (idx == CSR_COUNT_WHITE) begin
            count_white = data[0];
         end
      endfunction

      // largest y with y*y*65536*gaps <= k*k*sum, found by bisection
      function logic [LIMIT_W-1:0] rms_run_limit();
         logic [127:0]     lhs;
         logic [127:0]     rhs;
         logic [127:0]     y;
         logic [LIMIT_W:0] lo;
         logic [LIMIT_W:0] hi;
         logic [LIMIT_W:0] mid;
         if (gaps == 0) return '0;
         lo  = '0;
         hi  = {1'b0, {LIMIT_W{1'b1}}};
         rhs = 128'(scale_k) * 128'(scale_k) * 128'(sq_sum);
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            y   = 128'(mid);
            lhs = (y * y * 128'(gaps)) << 16;
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         return lo[LIMIT_W-1:0];
      endfunction

      function void note_request(logic [PIX_W-1:0] pix, logic last);
         logic        white;
         int unsigned sq;
         white = (pix > PIX_WHITE_LEVEL);
         if (white == count_white) begin
            if (run_len < RUN_MAX) run_len = run_len + 1'b1;
         end else begin
            sq = run_len * run_len;
            if (32'(sq_sum) + sq > SUM_CAP) begin
               sq_sum = SUM_W'(SUM_CAP);
            end else begin
               sq_sum = sq_sum + SUM_W'(sq);
            end
            if (gaps < LINE_MAX) gaps = gaps + 1'b1;
            run_len = '0;
         end
         if (last) begin
            limits_due.push_back(rms_run_limit());
            run_len = '0;
            gaps    = '0;
            sq_sum  = '0;
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] data);
         logic [LIMIT_W-1:0] want;
         if (limits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected line limit %0d with no line outstanding",
                        data[LIMIT_W-1:0]);
            return;
         end
         want = limits_due.pop_front();
         checked++;
         if (data[LIMIT_W-1:0] !== want || data[RSP_W-1:LIMIT_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("line %0d: limit expected %0d, got %0d (tdata %h)",
                        checked, want, data[LIMIT_W-1:0], data);
         end
      endfunction
   endclass

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_THIRDS,
      RX_COIN,
      RX_BLOCKED
   } stall_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   limit_checker board = new();

   int          pixels_sent  = 0;
   int          lines_sent   = 0;
   int          settings_run = 0;
   int          burst_left   = 0;
   bit          paced        = 1'b1;
   int unsigned ready_tick   = 0;
   stall_type   ready_mode   = RX_OPEN;

   rlsa_line_run_threshold_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Result back-pressure: re-pick the stall pattern as the tick's low bits
   // wrap: always ready, a one-in-three beat, a coin toss or long holds.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (ready_tick[5:0] == 6'd0) ready_mode <= stall_type'($urandom_range(0, 3));
      case (ready_mode)
         RX_OPEN: begin
            rsp_tready <= 1'b1;
         end
         RX_THIRDS: begin
            rsp_tready <= (ready_tick % 3 == 0);
         end
         RX_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= (ready_tick[3:0] >= 4'd12);
         end
      endcase
   end

   // Check every line limit on the edge that moves it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // Pick a pixel of the given colour, leaning on the extremes and on the
   // two values either side of the white level.
   function automatic logic [PIX_W-1:0] pick_pixel(logic white);
      case ($urandom_range(0, 7))
         0:       return white ? 8'd255 : 8'd0;
         1:       return white ? 8'd151 : 8'd150;
         default: return white ? 8'($urandom_range(151, 255)) : 8'($urandom_range(0, 150));
      endcase
   endfunction

   // Offer one pixel request and hold it until the core takes it. When pacing
   // is on, open each burst with a random gap.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
      int gap;
      if (paced) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(pix, last);
      pixels_sent++;
      if (last) lines_sent++;
   endtask

   task automatic send_run(input logic white, input int count, input logic end_line);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel(white), end_line && i == count - 1);
   endtask

   // One random line: colours persist for a while so that real runs form.
   task automatic send_line();
      int   len;
      logic white;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 14);
      white = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0) white = ~white;
         send_pixel(pick_pixel(white), i == len - 1);
      end
   endtask

   // Drop the request, drain every outstanding limit and let the core go idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.limits_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write scale_k and count_white, then an optional write to an unused index.
   // Hold csr_valid high across the writes and lower it once at the end.
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] k_val,
                                input logic [CSR_DATA_W-1:0] colour_val,
                                input int stray_idx);
      logic [CSR_IDX_W-1:0]  idx[3];
      logic [CSR_DATA_W-1:0] val[3];
      int                    n;
      idx[0] = CSR_SCALE_K;
      val[0] = k_val;
      idx[1] = CSR_COUNT_WHITE;
      val[1] = colour_val;
      n      = 2;
      if (stray_idx >= 0) begin
         idx[2] = CSR_IDX_W'(stray_idx);
         val[2] = CSR_DATA_W'($urandom_range(0, 65535));
         n      = 3;
      end
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         board.set_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_k[6];
      logic [CSR_DATA_W-1:0] phase_colour[6];
      int                    phase_stray[6];
      int                    start_count;

      phase_k      = '{16'h0000, 16'h0001, 16'hFFFF, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'h0100};
      phase_colour = '{16'h0000, 16'h0001, 16'hFFFE, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'hFFFF};
      phase_stray  = '{-1, 2, -1, $urandom_range(2, 255), -1, -1};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, k = 1.0 counting white runs.
      send_pixel(8'd255, 1'b1);  // all pixels in the run: no gap, limit zero
      send_pixel(8'd0, 1'b1);    // single gap after an empty run
      send_pixel(8'd151, 1'b0);
      send_pixel(8'd151, 1'b0);
      send_pixel(8'd151, 1'b0);
      send_pixel(8'd150, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b1);  // open run at line end is dropped
      settle();

      // Black runs, k = 3.5, with a stray write to the top index.
      apply_setting(16'h0380, 16'h0000, 255);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd150, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd151, 1'b0);
      send_pixel(8'd150, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd150, 1'b1);
      send_pixel(8'd151, 1'b0);
      send_pixel(8'd151, 1'b1);
      settle();

      // Longer lines at the largest k, streamed back to back.
      apply_setting(16'hFFFF, 16'h0001, -1);
      paced = 1'b0;
      send_run(1'b1, 64, 1'b0);           // one long run closed at the line end
      send_pixel(8'd0, 1'b1);
      send_run(1'b1, 40, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_run(1'b0, 30, 1'b0);           // many gaps, then a closed run
      send_run(1'b1, 12, 1'b0);
      send_pixel(8'd0, 1'b1);
      paced = 1'b1;
      settle();

      // Random lines under each setting; keep one phase free of request pauses.
      for (int p = 0; p < 6; p++) begin
         apply_setting(phase_k[p], phase_colour[p], phase_stray[p]);
         paced       = (p != 3);
         start_count = pixels_sent;
         while (pixels_sent - start_count < 35) send_line();
         settle();
      end
      paced = 1'b1;

      // Allow the last line end its full result latency, then judge.
      repeat (100) @(posedge clock);
      $display("%0d pixels over %0d lines under %0d register settings", pixels_sent,
               lines_sent, settings_run);
      $display("%0d line limits checked, %0d mismatches, %0d limits missing",
               board.checked, board.mismatches, board.limits_due.size());
      if (board.mismatches == 0 && board.limits_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog: the whole run needs well under a tenth of this.
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
